// ===== src/u8v_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package u8v_pkg;

    localparam int unsigned QDEPTH = 2;

    localparam logic [2:0] LEN_BAD  = 3'd0;
    localparam logic [2:0] LEN_NONE = 3'd0;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            present;
        logic            fin;
        logic            valid;
    } u8v_grp_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_BAD;
        if (b < 8'h80)
            len = 3'd1;
        else if (b >= 8'hC2 && b <= 8'hDF)
            len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF)
            len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4)
            len = 3'd4;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b1);
        logic ok;
        ok = 1'b1;
        if (lead == 8'hE0 && b1 < 8'hA0)
            ok = 1'b0;
        if (lead == 8'hED && b1 >= 8'hA0)
            ok = 1'b0;
        if (lead == 8'hF0 && b1 < 8'h90)
            ok = 1'b0;
        if (lead == 8'hF4 && b1 > 8'h8F)
            ok = 1'b0;
        return ok;
    endfunction

endpackage
`default_nettype wire

// ===== src/u8v_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u8v_decode
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              final_byte,
    output u8v_pkg::u8v_grp_t      grp,
    output logic                   push
);

    logic [2:0]      exp_reg, exp_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [2:0][7:0] held_reg, held_next;
    logic            drop_reg, drop_next;

    logic [2:0]      nres;
    logic            handled;
    logic            ok;
    logic [2:0]      len;

    always_comb
    begin
        exp_next  = exp_reg;
        cnt_next  = cnt_reg;
        held_next = held_reg;
        drop_next = drop_reg;
        handled   = 1'b0;
        nres      = 3'd0;
        grp       = '0;
        grp.present = 1'b1;
        grp.fin     = final_byte;
        len         = u8v_pkg::lead_len(in_byte);

        ok = u8v_pkg::is_cont(in_byte);
        if (cnt_reg == 2'd1)
            ok = ok && u8v_pkg::second_ok(held_reg[0], in_byte);

        if (exp_reg != u8v_pkg::LEN_NONE)
        begin
            if (ok)
            begin
                handled = 1'b1;
                if (({1'b0, cnt_reg} + 3'd1) >= exp_reg)
                begin
                    grp.bytes[0] = (cnt_reg > 2'd0) ? held_reg[0] : in_byte;
                    grp.bytes[1] = (cnt_reg > 2'd1) ? held_reg[1] : in_byte;
                    grp.bytes[2] = (cnt_reg > 2'd2) ? held_reg[2] : in_byte;
                    grp.bytes[3] = in_byte;
                    nres     = {1'b0, cnt_reg} + 3'd1;
                    exp_next = u8v_pkg::LEN_NONE;
                    cnt_next = 2'd0;
                end
                else
                begin
                    unique case (cnt_reg)
                        2'd1:    held_next[1] = in_byte;
                        2'd2:    held_next[2] = in_byte;
                        default: held_next[0] = held_reg[0];
                    endcase
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            else
            begin
                drop_next = 1'b1;
                exp_next  = u8v_pkg::LEN_NONE;
                cnt_next  = 2'd0;
                handled   = u8v_pkg::is_cont(in_byte);
            end
        end

        if (!handled)
        begin
            if (len == u8v_pkg::LEN_BAD)
                drop_next = 1'b1;
            else if (len == 3'd1)
            begin
                grp.bytes[0] = in_byte;
                nres = 3'd1;
            end
            else
            begin
                held_next[0] = in_byte;
                cnt_next     = 2'd1;
                exp_next     = len;
            end
        end

        if (final_byte)
        begin
            if (exp_next != u8v_pkg::LEN_NONE)
                drop_next = 1'b1;
            if (nres == 3'd0)
            begin
                grp.present  = 1'b0;
                grp.bytes[0] = 8'h00;
                nres = 3'd1;
            end
        end

        grp.valid    = !drop_next;
        grp.last_idx = nres[1:0] - 2'd1;
        push         = nres != 3'd0;

        if (final_byte)
        begin
            exp_next  = u8v_pkg::LEN_NONE;
            cnt_next  = 2'd0;
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= u8v_pkg::LEN_NONE;
            cnt_reg  <= 2'd0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((exp_reg == u8v_pkg::LEN_NONE) == (cnt_reg == 2'd0)))
        else $error("held count disagrees with open sequence");

    a_open_range: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg != u8v_pkg::LEN_NONE) |-> ({1'b0, cnt_reg} < exp_reg && exp_reg >= 3'd2))
        else $error("held count out of range for sequence length");

endmodule
`default_nettype wire

// ===== src/u8v_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module u8v_outq
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire u8v_pkg::u8v_grp_t grp,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   byte_present,
    output logic                   run_end,
    output logic                   string_end,
    output logic                   all_valid
);

    localparam logic [1:0] FULL = 2'(u8v_pkg::QDEPTH);

    u8v_pkg::u8v_grp_t slot_reg [u8v_pkg::QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;

    u8v_pkg::u8v_grp_t head;
    logic       pop_last;
    logic       do_pop;
    logic       do_push;

    assign head      = slot_reg[rd_ptr_reg];
    assign space     = cnt_reg != FULL;
    assign out_valid = cnt_reg != 2'd0;
    assign do_pop    = out_valid && out_ready;
    assign do_push   = push && space;
    assign pop_last  = do_pop && (idx_reg == head.last_idx);

    assign out_byte     = head.bytes[idx_reg];
    assign byte_present = head.present;
    assign run_end      = idx_reg == head.last_idx;
    assign string_end   = head.fin && (idx_reg == head.last_idx);
    assign all_valid    = head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = !wr_ptr_reg;
        if (do_pop)
        begin
            if (pop_last)
            begin
                idx_next    = 2'd0;
                rd_ptr_next = !rd_ptr_reg;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
        priority if (do_push && !pop_last)
            cnt_next = cnt_reg + 2'd1;
        else if (!do_push && pop_last)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= grp;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL)
        else $error("group queue overfilled");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0) |-> (idx_reg <= head.last_idx))
        else $error("result index past end of group");

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("group pushed into full queue");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (idx_reg == 2'd0))
        else $error("result index not cleared on empty queue");

endmodule
`default_nettype wire

// ===== src/utf8_strict_validate_sanitize_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Strict UTF-8 validator/sanitizer. One byte is taken per cycle on the slave
// side while s_axis_tready is high (tlast marks the last byte of a string).
// Complete, valid sequences come out whole; bad, stray and truncated bytes
// are dropped and clear the all_valid flag for the rest of the string. A byte
// yields 0 to 4 results, which drain one per cycle while m_axis_tready is high
// through a two-entry group queue; s_axis_tready drops only while both entries
// are occupied. A byte's results are registered into the group queue when
// the byte is accepted. With a ready sink the input can still stall when a
// multi-byte sequence is draining and further groups queue behind it (as
// when a four-byte character is followed by single bytes), so the rate is
// one byte per cycle only while the queue never fills.
module utf8_strict_validate_sanitize_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // final_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]      m_axis_tuser,   // [0] byte_present, [1] run_end, [2] all_valid
    output logic            m_axis_tlast    // string_end
);

    logic              accept;
    logic              push;
    logic              space;
    u8v_pkg::u8v_grp_t grp;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    u8v_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .grp        (grp),
        .push       (push)
    );

    u8v_outq u_outq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push && accept),
        .grp          (grp),
        .space        (space),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .byte_present (m_axis_tuser[0]),
        .run_end      (m_axis_tuser[1]),
        .string_end   (m_axis_tlast),
        .all_valid    (m_axis_tuser[2])
    );

endmodule
`default_nettype wire

// ===== verif/utf8_strict_validate_sanitize_top_test.sv =====
`timescale 1ns / 1ps
module utf8_strict_validate_sanitize_top_test;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } text_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       run_end;
        logic       str_end;
        logic       all_ok;
    } san_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    text_byte_t  src_bytes_q [$];
    san_result_t sanitized_q [$];

    logic [2:0] open_len = 3'd0;
    logic [1:0] held_n = 2'd0;
    logic [7:0] held_seq [3];
    logic       string_dropped = 1'b0;

    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int   src_gap_max = 12;
    int   sink_gap_max = 12;
    int   src_gap = 0;
    int   sink_wait = 0;
    int   hold_req_cnt = 0;
    int   hold_served = 0;
    int   hold_left = 0;

    int err_count = 0;
    int n_queued = 0;
    int n_strings = 0;
    int n_bytes = 0;
    int n_checked = 0;
    int n_status_only = 0;

    utf8_strict_validate_sanitize_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic bit is_tail(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic int lead_bytes(input logic [7:0] b);
        if (b < 8'h80)
            return 1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return 2;
        if (b >= 8'hE0 && b <= 8'hEF)
            return 3;
        if (b >= 8'hF0 && b <= 8'hF4)
            return 4;
        return 0;
    endfunction

    // overlong, surrogate and above-U+10FFFF checks on the second byte
    function automatic bit lead_allows(input logic [7:0] lead, input logic [7:0] b1);
        if (lead == 8'hE0 && b1 < 8'hA0)
            return 1'b0;
        if (lead == 8'hED && b1 >= 8'hA0)
            return 1'b0;
        if (lead == 8'hF0 && b1 < 8'h90)
            return 1'b0;
        if (lead == 8'hF4 && b1 > 8'h8F)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic void sanitize_step(input logic [7:0] b, input logic fin);
        logic [7:0]  outb [4];
        logic        outp [4];
        int          n;
        int          i;
        int          len;
        bit          used;
        bit          ok;
        san_result_t r;
        n = 0;
        used = 1'b0;
        if (open_len != 3'd0) begin
            ok = is_tail(b);
            if (ok && held_n == 2'd1)
                ok = lead_allows(held_seq[0], b);
            if (ok) begin
                used = 1'b1;
                if (int'(held_n) + 1 >= int'(open_len)) begin
                    for (i = 0; i < int'(held_n); i++) begin
                        outb[n] = held_seq[i];
                        outp[n] = 1'b1;
                        n++;
                    end
                    outb[n] = b;
                    outp[n] = 1'b1;
                    n++;
                    open_len = 3'd0;
                    held_n = 2'd0;
                end
                else begin
                    held_seq[held_n] = b;
                    held_n = held_n + 2'd1;
                end
            end
            else begin
                string_dropped = 1'b1;
                open_len = 3'd0;
                held_n = 2'd0;
                if (is_tail(b))
                    used = 1'b1;
            end
        end
        if (!used) begin
            len = lead_bytes(b);
            if (len == 0)
                string_dropped = 1'b1;
            else if (len == 1) begin
                outb[n] = b;
                outp[n] = 1'b1;
                n++;
            end
            else begin
                held_seq[0] = b;
                held_n = 2'd1;
                open_len = 3'(len);
            end
        end
        if (fin) begin
            if (open_len != 3'd0) begin
                string_dropped = 1'b1;
                open_len = 3'd0;
                held_n = 2'd0;
            end
            if (n == 0) begin
                outb[0] = 8'h00;
                outp[0] = 1'b0;
                n = 1;
            end
        end
        for (i = 0; i < n; i++) begin
            r.data = outb[i];
            r.present = outp[i];
            r.run_end = (i == n - 1);
            r.str_end = fin && (i == n - 1);
            r.all_ok = !string_dropped;
            sanitized_q.push_back(r);
        end
        if (fin)
            string_dropped = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (err_count < 40)
            $display("%0t mismatch: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
        err_count++;
    endtask

    task automatic check_result(input san_result_t got);
        san_result_t want;
        if (sanitized_q.size() == 0)
            report_mismatch("result with none pending, out_byte", 0, got.data);
        else begin
            want = sanitized_q.pop_front();
            n_checked++;
            if (!want.present)
                n_status_only++;
            if (got.data !== want.data)
                report_mismatch("out_byte", want.data, got.data);
            if (got.present !== want.present)
                report_mismatch("byte_present", want.present, got.present);
            if (got.run_end !== want.run_end)
                report_mismatch("run_end", want.run_end, got.run_end);
            if (got.str_end !== want.str_end)
                report_mismatch("string_end", want.str_end, got.str_end);
            if (got.all_ok !== want.all_ok)
                report_mismatch("all_valid", want.all_ok, got.all_ok);
        end
    endtask

    always @(posedge clk) begin
        req_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        res_taken <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            sanitize_step(s_axis_tdata, s_axis_tlast);
            n_bytes++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result('{data: m_axis_tdata, present: m_axis_tuser[0],
                           run_end: m_axis_tuser[1], str_end: m_axis_tlast,
                           all_ok: m_axis_tuser[2]});
    end

    // request driver
    always @(negedge clk) begin
        text_byte_t cur;
        if (rst_n && (!s_axis_tvalid || req_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (src_bytes_q.size() > 0) begin
                cur = src_bytes_q.pop_front();
                s_axis_tdata <= cur.b;
                s_axis_tlast <= cur.fin;
                s_axis_tvalid <= 1'b1;
                src_gap = $urandom_range(0, src_gap_max);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result sink
    always @(negedge clk) begin
        logic rdy;
        if (res_taken)
            sink_wait = $urandom_range(0, sink_gap_max);
        if (hold_req_cnt != hold_served) begin
            hold_served = hold_req_cnt;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (sink_wait > 0) begin
            sink_wait--;
            rdy = 1'b0;
        end
        else
            rdy = 1'b1;
        m_axis_tready <= rdy;
    end

    task automatic queue_byte(input logic [7:0] b, input logic fin = 1'b0);
        src_bytes_q.push_back('{b: b, fin: fin});
        n_queued++;
        if (fin)
            n_strings++;
    endtask

    function automatic int unsigned pick_codepoint();
        int unsigned edges [10] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800,
                                    32'hD7FF, 32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF};
        int unsigned cp;
        case ($urandom_range(0, 9))
            0: cp = edges[$urandom_range(0, 9)];
            1, 2, 3: cp = $urandom_range(0, 32'h7F);
            4, 5: cp = $urandom_range(32'h80, 32'h7FF);
            6, 7:
            begin
                cp = $urandom_range(32'h800, 32'hFFFF);
                if (cp >= 32'hD800 && cp <= 32'hDFFF)
                    cp = cp ^ 32'h1000;
            end
            default: cp = $urandom_range(32'h10000, 32'h10FFFF);
        endcase
        return cp;
    endfunction

    function automatic int encode_utf8(input int unsigned cp, output logic [3:0][7:0] enc);
        enc = '0;
        if (cp < 32'h80) begin
            enc[0] = 8'(cp);
            return 1;
        end
        if (cp < 32'h800) begin
            enc[0] = 8'hC0 | 8'(cp >> 6);
            enc[1] = 8'h80 | 8'(cp & 32'h3F);
            return 2;
        end
        if (cp < 32'h10000) begin
            enc[0] = 8'hE0 | 8'(cp >> 12);
            enc[1] = 8'h80 | 8'((cp >> 6) & 32'h3F);
            enc[2] = 8'h80 | 8'(cp & 32'h3F);
            return 3;
        end
        enc[0] = 8'hF0 | 8'(cp >> 18);
        enc[1] = 8'h80 | 8'((cp >> 12) & 32'h3F);
        enc[2] = 8'h80 | 8'((cp >> 6) & 32'h3F);
        enc[3] = 8'h80 | 8'(cp & 32'h3F);
        return 4;
    endfunction

    // mostly well-formed text; some noise, corrupted and truncated sequences
    task automatic queue_random_string();
        int              units;
        int              kind;
        int              nb;
        int              keep;
        int              i;
        logic [3:0][7:0] enc;
        units = $urandom_range(1, 5);
        repeat (units) begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
                queue_byte(8'($urandom_range(0, 255)));
            else begin
                nb = encode_utf8(pick_codepoint(), enc);
                keep = nb;
                if (kind >= 88 && nb > 1)
                    keep = $urandom_range(1, nb - 1);
                else if (kind >= 76)
                    enc[$urandom_range(0, nb - 1)] = 8'($urandom_range(0, 255));
                for (i = 0; i < keep; i++)
                    queue_byte(enc[i]);
            end
        end
        src_bytes_q[src_bytes_q.size() - 1].fin = 1'b1;
        n_strings++;
    endtask

    task automatic queue_random_bytes(input int count);
        int target;
        target = n_queued + count;
        while (n_queued < target)
            queue_random_string();
    endtask

    task automatic wait_drained();
        while (src_bytes_q.size() != 0 || s_axis_tvalid || sanitized_q.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        queue_byte(8'h00);
        queue_byte(8'hDF);
        queue_byte(8'hBF);
        queue_byte(8'hE0);
        queue_byte(8'hA0);
        queue_byte(8'h80);
        queue_byte(8'hF4);
        queue_byte(8'h8F);
        queue_byte(8'hBF);
        queue_byte(8'hBF);
        queue_byte(8'h7F, 1'b1);
        // bad second bytes
        queue_byte(8'hE0);
        queue_byte(8'h9F);
        queue_byte(8'hED);
        queue_byte(8'hA0);
        queue_byte(8'hF0);
        queue_byte(8'h8F);
        queue_byte(8'hF4);
        queue_byte(8'h90, 1'b1);
        // strays, failure with rescan, truncated tail
        queue_byte(8'hC0);
        queue_byte(8'hF5);
        queue_byte(8'h80);
        queue_byte(8'hC2);
        queue_byte(8'h41);
        queue_byte(8'hF0);
        queue_byte(8'h90, 1'b1);
        wait_drained();

        src_gap_max = 0;
        sink_gap_max = 0;
        queue_random_bytes(25);
        wait_drained();

        hold_req_cnt++;
        queue_random_bytes(25);
        wait_drained();

        src_gap_max = 12;
        sink_gap_max = 12;
        queue_random_bytes(30);
        wait_drained();

        repeat (20) @(posedge clk);
        if (sanitized_q.size() != 0)
            report_mismatch("results still pending at end, count", 0, sanitized_q.size());
        $display("run covered %0d strings, %0d bytes sent, %0d results checked",
                 n_strings, n_bytes, n_checked);
        $display("%0d status-only results, %0d mismatches", n_status_only, err_count);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
